FILE: hdl/nonuniform_advdiff_stencil_update_assert.svh
// Assertion shorthands for the stencil update block.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef NONUNIFORM_ADVDIFF_STENCIL_UPDATE_ASSERT_SVH
`define NONUNIFORM_ADVDIFF_STENCIL_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NADV_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NADV_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/nadv_pkg.sv
`default_nettype none
package nadv_pkg;

  // Field widths and fixed-point format.
  localparam int VALUE_WIDTH   = 32;
  localparam int SPACING_WIDTH = 16;
  localparam int REG_WIDTH     = 32;
  localparam int FRAC_BITS     = 16;

  // Internal wide word and clamped magnitude widths.
  localparam int WIDE_W = 64;
  localparam int MAG_W  = 62;
  localparam int MAG_H  = MAG_W / 2;
  localparam int CMAG_W = REG_WIDTH + 1;

  // Divider geometry: two quotient bits per stage.
  localparam int DEN_W      = SPACING_WIDTH + 1;
  localparam int DIV_STAGES = (MAG_W + DEN_W + 1) / 2;
  localparam int DIV_NUM_W  = 2 * DIV_STAGES;
  localparam int DIV_LAT    = DIV_STAGES + 3;

  // Stage counts of the larger units and of the whole pipeline.
  localparam int AXIS_LAT = 2 * DIV_LAT + 2;
  localparam int MULC_LAT = 3;
  localparam int PIPE_LAT = AXIS_LAT + 2 * MULC_LAT + 3;

  // Bound applied to every intermediate value.
  localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sh1FFF_FFFF_FFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TIME_STEP  = 2'd0,
    REG_DIFFUSION  = 2'd1,
    REG_VELOCITY_X = 2'd2,
    REG_VELOCITY_Y = 2'd3
  } reg_index_t;

  // Sign-magnitude form of a scale coefficient.
  typedef struct packed {
    logic              neg;
    logic [CMAG_W-1:0] mag;
  } coeff_t;

  // Clamp a widened sum back into the intermediate range.
  function automatic logic signed [WIDE_W-1:0] clamp_wide(input logic signed [WIDE_W:0] x);
    logic signed [WIDE_W:0] lim;
    lim = (WIDE_W+1)'(WIDE_LIM);
    if (x > lim) begin
      return WIDE_LIM;
    end else if (x < -lim) begin
      return -WIDE_LIM;
    end
    return WIDE_W'(x);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/nonuniform_advdiff_stencil_update.sv
`default_nettype none
// Forward-Euler advection-diffusion update of one point of a non-uniform
// 2-D grid. A beat carries the center value, four neighbors, four spacings
// and an interior flag; the result beat carries the new value and a flag
// that tells whether it was clipped. The block takes one beat per cycle while
// the output is not stalled. The pipeline depth is set mainly by two chained
// divider pipelines per axis (slopes, then the span-normalized terms), each
// resolving two quotient bits per stage over 40 stages. A stall at the output
// freezes the whole pipeline. The four registers are to be written through
// cfg_write only while no beat is in flight; the block itself does not
// enforce this.
module nonuniform_advdiff_stencil_update import nadv_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [REG_WIDTH-1:0]          cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] center_value,
  input  wire logic signed [VALUE_WIDTH-1:0] west_value,
  input  wire logic signed [VALUE_WIDTH-1:0] east_value,
  input  wire logic signed [VALUE_WIDTH-1:0] south_value,
  input  wire logic signed [VALUE_WIDTH-1:0] north_value,
  input  wire logic [SPACING_WIDTH-1:0]      west_spacing,
  input  wire logic [SPACING_WIDTH-1:0]      east_spacing,
  input  wire logic [SPACING_WIDTH-1:0]      south_spacing,
  input  wire logic [SPACING_WIDTH-1:0]      north_spacing,
  input  wire logic                          is_interior,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0]      new_value,
  output logic                               saturated
);

  `include "nonuniform_advdiff_stencil_update_assert.svh"

  localparam logic signed [WIDE_W:0] VAL_MAX =
    {{(WIDE_W-VALUE_WIDTH+2){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W:0] VAL_MIN = ~VAL_MAX;

  // Configuration registers.
  logic [REG_WIDTH-1:0] time_step;
  logic [REG_WIDTH-1:0] diffusion_coeff;
  logic [REG_WIDTH-1:0] velocity_x;
  logic [REG_WIDTH-1:0] velocity_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= '0;
      diffusion_coeff <= '0;
      velocity_x      <= '0;
      velocity_y      <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_TIME_STEP:  time_step       <= cfg_data;
        REG_DIFFUSION:  diffusion_coeff <= cfg_data;
        REG_VELOCITY_X: velocity_x      <= cfg_data;
        REG_VELOCITY_Y: velocity_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sign-magnitude form of a signed register.
  function automatic coeff_t coeff_of(input logic [REG_WIDTH-1:0] r);
    logic signed [CMAG_W-1:0] ext;
    coeff_t c;
    ext   = CMAG_W'(signed'(r));
    c.neg = ext[CMAG_W-1];
    c.mag = c.neg ? CMAG_W'(-ext) : CMAG_W'(ext);
    return c;
  endfunction

  coeff_t c_diff;
  coeff_t c_vx;
  coeff_t c_vy;
  coeff_t c_dt;

  assign c_diff = coeff_of(diffusion_coeff);
  assign c_vx   = coeff_of(velocity_x);
  assign c_vy   = coeff_of(velocity_y);
  assign c_dt   = '{neg: 1'b0, mag: {time_step, 1'b0}};

  // The whole pipeline moves unless a finished result is held.
  logic en;
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  // Valid bits and the values needed at the last stage.
  logic [PIPE_LAT-2:0]             vpipe;
  logic signed [VALUE_WIDTH-1:0]   u_d   [PIPE_LAT-1];
  logic                            int_d [PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_LAT-3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_d[0]   <= center_value;
      int_d[0] <= is_interior;
      for (int i = 1; i < PIPE_LAT - 1; i++) begin
        u_d[i]   <= u_d[i-1];
        int_d[i] <= int_d[i-1];
      end
    end
  end

  // Per-axis diffusion and central slope.
  logic signed [WIDE_W-1:0] lx;
  logic signed [WIDE_W-1:0] ax;
  logic signed [WIDE_W-1:0] ly;
  logic signed [WIDE_W-1:0] ay;

  nadv_axis u_axis_x (
    .clk, .en, .u(center_value), .lo_v(west_value), .hi_v(east_value),
    .h_lo_raw(west_spacing), .h_hi_raw(east_spacing), .diff(lx), .slope(ax)
  );

  nadv_axis u_axis_y (
    .clk, .en, .u(center_value), .lo_v(south_value), .hi_v(north_value),
    .h_lo_raw(south_spacing), .h_hi_raw(north_spacing), .diff(ly), .slope(ay)
  );

  // Laplacian sum.
  logic signed [WIDE_W-1:0] dsum;
  logic signed [WIDE_W-1:0] ax_r;
  logic signed [WIDE_W-1:0] ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dsum <= clamp_wide((WIDE_W+1)'(lx) + (WIDE_W+1)'(ly));
      ax_r <= ax;
      ay_r <= ay;
    end
  end

  // Coefficient products.
  logic signed [WIDE_W-1:0] t_diff;
  logic signed [WIDE_W-1:0] t_vx;
  logic signed [WIDE_W-1:0] t_vy;

  nadv_mulc u_mul_diff (.clk, .en, .x(dsum), .coeff(c_diff), .prod(t_diff));
  nadv_mulc u_mul_vx   (.clk, .en, .x(ax_r), .coeff(c_vx),   .prod(t_vx));
  nadv_mulc u_mul_vy   (.clk, .en, .x(ay_r), .coeff(c_vy),   .prod(t_vy));

  // Rate of change.
  logic signed [WIDE_W-1:0] rate;

  always_ff @(posedge clk) begin
    if (en) begin
      rate <= clamp_wide((WIDE_W+1)'(t_diff) + (WIDE_W+1)'(t_vx) + (WIDE_W+1)'(t_vy));
    end
  end

  // Increment over twice the time step.
  logic signed [WIDE_W-1:0] inc;

  nadv_mulc u_mul_dt (.clk, .en, .x(rate), .coeff(c_dt), .prod(inc));

  // Final add with saturation; boundary points pass through.
  logic signed [WIDE_W:0] sum_r;
  assign sum_r = (WIDE_W+1)'(u_d[PIPE_LAT-2]) + (WIDE_W+1)'(inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vpipe[PIPE_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!int_d[PIPE_LAT-2]) begin
        new_value <= u_d[PIPE_LAT-2];
        saturated <= 1'b0;
      end else if (sum_r > VAL_MAX) begin
        new_value <= VALUE_WIDTH'(VAL_MAX);
        saturated <= 1'b1;
      end else if (sum_r < VAL_MIN) begin
        new_value <= VALUE_WIDTH'(VAL_MIN);
        saturated <= 1'b1;
      end else begin
        new_value <= VALUE_WIDTH'(sum_r);
        saturated <= 1'b0;
      end
    end
  end

  // A stall must freeze every valid bit in flight.
  `NADV_CHECK_NEXT(a_stall_freeze, !en, $stable(vpipe) && $stable(out_valid), "valid bits moved during a stall")
  // An accepted beat must enter the first stage.
  `NADV_CHECK_NEXT(a_accept_enters, in_valid && in_ready, vpipe[0], "accepted beat was not captured")
  // A clipped result sits on one of the rails.
  `NADV_CHECK_SAME(a_sat_rail, out_valid && saturated, (new_value == VALUE_WIDTH'(VAL_MAX)) || (new_value == VALUE_WIDTH'(VAL_MIN)), "saturated result is off the rails")
  // A held result stays put.
  `NADV_CHECK_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(new_value) && $stable(saturated), "held result changed")

endmodule
`default_nettype wire

FILE: hdl/nadv_div.sv
`default_nettype none
module nadv_div import nadv_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [WIDE_W-1:0] x,
  input  wire logic [DEN_W-1:0]         mult,
  input  wire logic [DEN_W-1:0]         den,
  output logic signed [WIDE_W-1:0]      quot
);

  localparam logic [DIV_NUM_W-1:0] LIM_Q = DIV_NUM_W'(WIDE_LIM);

  // Magnitude stage.
  logic [MAG_W-1:0] mag_a;
  logic             neg_a;
  logic [DEN_W-1:0] mult_a;
  logic [DEN_W-1:0] den_a;

  // Division stages; entry 0 holds the product that is divided.
  logic [DIV_NUM_W-1:0] num_s [DIV_STAGES+1];
  logic [DEN_W-1:0]     rem_s [DIV_STAGES+1];
  logic [DEN_W-1:0]     den_s [DIV_STAGES+1];
  logic                 neg_s [DIV_STAGES+1];
  logic [DIV_NUM_W-1:0] num_next [DIV_STAGES];
  logic [DEN_W-1:0]     rem_next [DIV_STAGES];

  logic signed [WIDE_W-1:0] abs_x;
  logic [MAG_W-1:0]         mag_q;

  assign abs_x = x[WIDE_W-1] ? -x : x;

  // Take the magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a  <= abs_x[MAG_W-1:0];
      neg_a  <= x[WIDE_W-1];
      mult_a <= mult;
      den_a  <= den;
    end
  end

  // Two restoring steps per stage.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
    always_comb begin
      logic [DEN_W:0]     t;
      logic [DEN_W-1:0]   r;
      logic [DIV_NUM_W-1:0] n;
      r = rem_s[i];
      n = num_s[i];
      for (int k = 0; k < 2; k++) begin
        t = {r, n[DIV_NUM_W-1]};
        n = {n[DIV_NUM_W-2:0], 1'b0};
        if (t >= {1'b0, den_s[i]}) begin
          t    = t - {1'b0, den_s[i]};
          n[0] = 1'b1;
        end
        r = t[DEN_W-1:0];
      end
      rem_next[i] = r;
      num_next[i] = n;
    end
  end

  // Form the full numerator, then advance every division stage.
  always_ff @(posedge clk) begin
    if (en) begin
      num_s[0] <= DIV_NUM_W'(mag_a * mult_a);
      rem_s[0] <= '0;
      den_s[0] <= den_a;
      neg_s[0] <= neg_a;
      for (int i = 0; i < DIV_STAGES; i++) begin
        num_s[i+1] <= num_next[i];
        rem_s[i+1] <= rem_next[i];
        den_s[i+1] <= den_s[i];
        neg_s[i+1] <= neg_s[i];
      end
    end
  end

  // Clamp the quotient and restore the sign.
  assign mag_q = (num_s[DIV_STAGES] > LIM_Q) ? MAG_W'(WIDE_LIM)
                                             : num_s[DIV_STAGES][MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= neg_s[DIV_STAGES] ? -signed'(WIDE_W'(mag_q)) : signed'(WIDE_W'(mag_q));
    end
  end

endmodule
`default_nettype wire

FILE: hdl/nadv_axis.sv
`default_nettype none
module nadv_axis import nadv_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [VALUE_WIDTH-1:0] u,
  input  wire logic signed [VALUE_WIDTH-1:0] lo_v,
  input  wire logic signed [VALUE_WIDTH-1:0] hi_v,
  input  wire logic [SPACING_WIDTH-1:0]      h_lo_raw,
  input  wire logic [SPACING_WIDTH-1:0]      h_hi_raw,
  output logic signed [WIDE_W-1:0]           diff,
  output logic signed [WIDE_W-1:0]           slope
);

  localparam logic [DEN_W-1:0] ONE_SP = {1'b1, {SPACING_WIDTH{1'b0}}};

  logic [DEN_W-1:0]         h_lo;
  logic [DEN_W-1:0]         h_hi;
  logic signed [WIDE_W-1:0] x_lo;
  logic signed [WIDE_W-1:0] x_hi;
  logic signed [WIDE_W-1:0] g_lo;
  logic signed [WIDE_W-1:0] g_hi;

  // A zero spacing counts as the smallest spacing.
  assign h_lo = (h_lo_raw == '0) ? DEN_W'(1) : DEN_W'(h_lo_raw);
  assign h_hi = (h_hi_raw == '0) ? DEN_W'(1) : DEN_W'(h_hi_raw);
  assign x_lo = WIDE_W'(u) - WIDE_W'(lo_v);
  assign x_hi = WIDE_W'(hi_v) - WIDE_W'(u);

  // One-sided slopes.
  nadv_div u_div_lo (.clk, .en, .x(x_lo), .mult(ONE_SP), .den(h_lo), .quot(g_lo));
  nadv_div u_div_hi (.clk, .en, .x(x_hi), .mult(ONE_SP), .den(h_hi), .quot(g_hi));

  // Spacings wait for the slopes.
  logic [DEN_W-1:0] hlo_d [DIV_LAT];
  logic [DEN_W-1:0] hhi_d [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      hlo_d[0] <= h_lo;
      hhi_d[0] <= h_hi;
      for (int i = 1; i < DIV_LAT; i++) begin
        hlo_d[i] <= hlo_d[i-1];
        hhi_d[i] <= hhi_d[i-1];
      end
    end
  end

  // Slope difference and span.
  logic signed [WIDE_W-1:0] dg;
  logic signed [WIDE_W-1:0] glo_r;
  logic [DEN_W-1:0]         span;
  logic [DEN_W-1:0]         hlo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dg    <= clamp_wide((WIDE_W+1)'(g_hi) - (WIDE_W+1)'(g_lo));
      glo_r <= g_lo;
      span  <= hlo_d[DIV_LAT-1] + hhi_d[DIV_LAT-1];
      hlo_r <= hlo_d[DIV_LAT-1];
    end
  end

  // Diffusion part and weighted slope part.
  logic signed [WIDE_W-1:0] q_diff;
  logic signed [WIDE_W-1:0] q_slope;

  nadv_div u_div_diff  (.clk, .en, .x(dg), .mult(ONE_SP), .den(span), .quot(q_diff));
  nadv_div u_div_slope (.clk, .en, .x(dg), .mult(hlo_r),  .den(span), .quot(q_slope));

  logic signed [WIDE_W-1:0] glo_d [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      glo_d[0] <= glo_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        glo_d[i] <= glo_d[i-1];
      end
    end
  end

  // Central slope is the lower slope plus the weighted difference.
  always_ff @(posedge clk) begin
    if (en) begin
      diff  <= q_diff;
      slope <= clamp_wide((WIDE_W+1)'(glo_d[DIV_LAT-1]) + (WIDE_W+1)'(q_slope));
    end
  end

endmodule
`default_nettype wire

FILE: hdl/nadv_mulc.sv
`default_nettype none
module nadv_mulc import nadv_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [WIDE_W-1:0] x,
  input  wire coeff_t                   coeff,
  output logic signed [WIDE_W-1:0]      prod
);

  localparam int FULL_W = MAG_W + CMAG_W;
  localparam logic [FULL_W-1:0] LIM_F = FULL_W'(WIDE_LIM);

  logic signed [WIDE_W-1:0] abs_x;
  logic [MAG_W-1:0]         mag_a;
  logic                     neg_a;
  logic [CMAG_W-1:0]        cmag_a;
  logic [MAG_H+CMAG_W-1:0]  p_lo;
  logic [MAG_H+CMAG_W-1:0]  p_hi;
  logic                     neg_b;
  logic [FULL_W-1:0]        full;
  logic [FULL_W-1:0]        scaled;
  logic [MAG_W-1:0]         mag_q;

  assign abs_x = x[WIDE_W-1] ? -x : x;

  // Magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a  <= abs_x[MAG_W-1:0];
      neg_a  <= x[WIDE_W-1] ^ coeff.neg;
      cmag_a <= coeff.mag;
    end
  end

  // Two partial products over the halves of the magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo  <= mag_a[MAG_H-1:0] * cmag_a;
      p_hi  <= mag_a[MAG_W-1:MAG_H] * cmag_a;
      neg_b <= neg_a;
    end
  end

  // Recombine, drop the fraction bits, clamp and sign.
  assign full   = {p_hi, {MAG_H{1'b0}}} + FULL_W'(p_lo);
  assign scaled = full >> FRAC_BITS;
  assign mag_q  = (scaled > LIM_F) ? MAG_W'(WIDE_LIM) : scaled[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= neg_b ? -signed'(WIDE_W'(mag_q)) : signed'(WIDE_W'(mag_q));
    end
  end

endmodule
`default_nettype wire
